>>> design/pidc_pkg.sv
// Shared types, constants and helpers for the PID controller block.
package pidc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int SUM_WIDTH_DEF = 48;

   // shared multiplier: 33x33 signed covers signed 32-bit and unsigned 32-bit operands
   localparam int MUL_WIDTH  = 33;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   // exact sum of the three gain products (largest term is below 2^95)
   localparam int ACC_WIDTH  = 98;

   localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_GAIN_P = 2'd0;
   localparam logic [1:0] REG_GAIN_I = 2'd1;
   localparam logic [1:0] REG_GAIN_D = 2'd2;

   // what the top level does with a product once it comes out of the multiplier
   typedef enum logic [1:0] {
      MK_INC,      // integral increment, goes into the running sum
      MK_FIRST,    // first gain term, loads the accumulator
      MK_ADD,      // further gain term
      MK_ADD_HI    // upper half of the integral term, weighted by 2^32
   } mul_kind_type;

   typedef struct packed {
      logic         valid;
      mul_kind_type kind;
   } mul_tag_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_INTEG,
      ST_PROP,
      ST_SUM_LO,
      ST_SUM_HI,
      ST_DERIV,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] value);
      logic signed [31:0] result;
      if (value[32] != value[31]) begin
         result = value[32] ? INT32_MIN : INT32_MAX;
      end else begin
         result = value[31:0];
      end
      return result;
   endfunction

endpackage

>>> design/pidc_mul.sv
// Shared 33x33 signed multiplier with registered product and tag.
module pidc_mul (
   input  logic                                      clock,
   input  logic                                      reset,
   input  pidc_pkg::mul_tag_type                     issue_tag,
   input  logic signed [pidc_pkg::MUL_WIDTH-1:0]     op_a,
   input  logic signed [pidc_pkg::MUL_WIDTH-1:0]     op_b,
   output logic signed [pidc_pkg::PROD_WIDTH-1:0]    product,
   output pidc_pkg::mul_tag_type                     product_tag
);

   logic signed [pidc_pkg::PROD_WIDTH-1:0] product_ff;
   pidc_pkg::mul_tag_type                  tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= issue_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_tag.valid) begin
         product_ff <= op_a * op_b;
      end
   end

   assign product     = product_ff;
   assign product_tag = tag_ff;

endmodule

>>> design/pidc_div.sv
// Radix-2 restoring divider for the error-difference derivative, saturated to 32 bits.
module pidc_div #(
   parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] diff,
   input  logic [31:0]        step_time,
   output logic               busy,
   output logic signed [31:0] quotient
);

   localparam int DIV_WIDTH  = 33 + FRAC_BITS;
   localparam int HEAD_WIDTH = DIV_WIDTH - 32;

   logic [32:0]            mag;
   logic [DIV_WIDTH-1:0]   dividend;
   logic [HEAD_WIDTH-1:0]  head;
   logic                   overflow;
   logic [32:0]            trial;
   logic                   fits;

   logic                   busy_ff;
   logic [4:0]             count_ff;
   logic                   ovf_ff;
   logic                   neg_ff;
   logic [31:0]            rem_ff;
   logic [31:0]            low_ff;
   logic [31:0]            quo_ff;

   assign mag      = diff[32] ? (33'd0 - $unsigned(diff)) : $unsigned(diff);
   assign dividend = {mag, {FRAC_BITS{1'b0}}};
   assign head     = dividend[DIV_WIDTH-1:32];
   // quotient would need more than 32 bits: saturate without iterating
   assign overflow = 32'(head) >= step_time;

   assign trial = {rem_ff, low_ff[31]};
   assign fits  = trial >= {1'b0, step_time};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= !overflow;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ovf_ff <= overflow;
         neg_ff <= diff[32];
         rem_ff <= 32'(head);
         low_ff <= dividend[31:0];
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? 32'(trial - {1'b0, step_time}) : trial[31:0];
         low_ff <= {low_ff[30:0], 1'b0};
         quo_ff <= {quo_ff[30:0], fits};
      end
   end

   always_comb begin
      if (ovf_ff || quo_ff[31]) begin
         quotient = neg_ff ? pidc_pkg::INT32_MIN : pidc_pkg::INT32_MAX;
      end else if (neg_ff) begin
         quotient = 32'sd0 - $signed(quo_ff);
      end else begin
         quotient = $signed(quo_ff);
      end
   end

   assign busy = busy_ff;

endmodule

>>> design/pid_controller_unit.sv
// Top level: one PID step per input transfer on signed fixed point, APB gain registers.
// In mode 0 with a nonzero step and a quotient within 32 bits, the derivative step waits
// for the 32-step radix-2 divider; the next input is taken only once the result is loaded.
// The shared 33x33 multiplier runs five products per item. Synchronous reset clears
// gains, integral, last error and all control; no memories, so no clearing pass.
module pid_controller_unit #(
   parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
   parameter int SUM_WIDTH = pidc_pkg::SUM_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] target, [63:32] target_rate, [95:64] measured, [127:96] measured_rate,
   // [159:128] step_time
   input  logic [159:0] req_tdata,
   // [0] req_type
   input  logic [0:0]   req_tuser,
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] drive
   output logic [31:0]  rsp_tdata,
   // [0] div_fault
   output logic [0:0]   rsp_tuser,
   // configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int ACC_W  = pidc_pkg::ACC_WIDTH;
   localparam int MUL_W  = pidc_pkg::MUL_WIDTH;
   localparam int PROD_W = pidc_pkg::PROD_WIDTH;
   localparam int EXT_W  = PROD_W + 1;

   localparam logic signed [EXT_W-1:0] SUM_MAX = (EXT_W'(1) <<< (SUM_WIDTH - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] SUM_MIN = -SUM_MAX - EXT_W'(1);
   localparam logic signed [ACC_W-1:0] DRIVE_MAX = ACC_W'(pidc_pkg::INT32_MAX);
   localparam logic signed [ACC_W-1:0] DRIVE_MIN = ACC_W'(pidc_pkg::INT32_MIN);

   pidc_pkg::state_type state_ff, state_in;

   // gains
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic               csr_write;

   // captured item
   logic               type_ff;
   logic signed [31:0] target_ff, trate_ff, measured_ff, mrate_ff;
   logic [31:0]        dt_ff;

   // datapath state
   logic signed [31:0]          err_ff;
   logic signed [31:0]          last_error_ff;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [63:0]          sum_wide;
   logic signed [31:0]          deriv_ff;
   logic                        use_div_ff;
   logic                        fault_ff;
   logic signed [ACC_W-1:0]     acc_ff;

   // output register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_drive_ff;
   logic               rsp_fault_ff;

   // multiplier and divider hookup
   pidc_pkg::mul_tag_type       issue_tag, product_tag;
   logic signed [MUL_W-1:0]     op_a, op_b;
   logic signed [PROD_W-1:0]    product;
   logic                        div_start, div_busy;
   logic signed [32:0]          div_diff;
   logic signed [31:0]          div_quotient;
   logic signed [31:0]          deriv_op;

   logic signed [PROD_W-1:0]    inc;
   logic signed [EXT_W-1:0]     sum_total;
   logic signed [ACC_W-1:0]     acc_shifted;
   logic signed [31:0]          drive_value;
   logic                        load_rsp;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            pidc_pkg::REG_GAIN_P: gain_p_ff <= $signed(csr_pwdata);
            pidc_pkg::REG_GAIN_I: gain_i_ff <= $signed(csr_pwdata);
            pidc_pkg::REG_GAIN_D: gain_d_ff <= $signed(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         pidc_pkg::REG_GAIN_P: csr_prdata = gain_p_ff;
         pidc_pkg::REG_GAIN_I: csr_prdata = gain_i_ff;
         pidc_pkg::REG_GAIN_D: csr_prdata = gain_d_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   assign req_tready = (state_ff == pidc_pkg::ST_IDLE);
   assign load_rsp   = (state_ff == pidc_pkg::ST_OUTPUT) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      issue_tag = '0;
      op_a      = '0;
      op_b      = '0;
      case (state_ff)
         pidc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = pidc_pkg::ST_ERROR;
            end
         end
         pidc_pkg::ST_ERROR: begin
            state_in = pidc_pkg::ST_INTEG;
         end
         pidc_pkg::ST_INTEG: begin
            issue_tag = '{valid: 1'b1, kind: pidc_pkg::MK_INC};
            op_a      = MUL_W'(err_ff);
            op_b      = $signed({1'b0, dt_ff});
            state_in  = pidc_pkg::ST_PROP;
         end
         pidc_pkg::ST_PROP: begin
            issue_tag = '{valid: 1'b1, kind: pidc_pkg::MK_FIRST};
            op_a      = MUL_W'(err_ff);
            op_b      = MUL_W'(gain_p_ff);
            state_in  = pidc_pkg::ST_SUM_LO;
         end
         pidc_pkg::ST_SUM_LO: begin
            // low half of the integral is unsigned
            issue_tag = '{valid: 1'b1, kind: pidc_pkg::MK_ADD};
            op_a      = $signed({1'b0, sum_wide[31:0]});
            op_b      = MUL_W'(gain_i_ff);
            state_in  = pidc_pkg::ST_SUM_HI;
         end
         pidc_pkg::ST_SUM_HI: begin
            issue_tag = '{valid: 1'b1, kind: pidc_pkg::MK_ADD_HI};
            op_a      = MUL_W'($signed(sum_wide[63:32]));
            op_b      = MUL_W'(gain_i_ff);
            state_in  = pidc_pkg::ST_DERIV;
         end
         pidc_pkg::ST_DERIV: begin
            if (!div_busy) begin
               issue_tag = '{valid: 1'b1, kind: pidc_pkg::MK_ADD};
               op_a      = MUL_W'(deriv_op);
               op_b      = MUL_W'(gain_d_ff);
               state_in  = pidc_pkg::ST_FINISH;
            end
         end
         pidc_pkg::ST_FINISH: begin
            state_in = pidc_pkg::ST_OUTPUT;
         end
         pidc_pkg::ST_OUTPUT: begin
            if (load_rsp) begin
               state_in = pidc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pidc_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- item capture and error ----------------
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         type_ff     <= req_tuser[0];
         target_ff   <= $signed(req_tdata[31:0]);
         trate_ff    <= $signed(req_tdata[63:32]);
         measured_ff <= $signed(req_tdata[95:64]);
         mrate_ff    <= $signed(req_tdata[127:96]);
         dt_ff       <= req_tdata[159:128];
      end
      if (state_ff == pidc_pkg::ST_ERROR) begin
         err_ff <= pidc_pkg::sat32(33'(target_ff) - 33'(measured_ff));
      end
   end

   // derivative setup; last error moves on in mode 0 even for a zero step
   assign div_diff  = 33'(err_ff) - 33'(last_error_ff);
   assign div_start = (state_ff == pidc_pkg::ST_INTEG) && !type_ff && (dt_ff != '0);
   assign deriv_op  = use_div_ff ? div_quotient : deriv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
      end else if ((state_ff == pidc_pkg::ST_INTEG) && !type_ff) begin
         last_error_ff <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pidc_pkg::ST_INTEG) begin
         use_div_ff <= div_start;
         fault_ff   <= !type_ff && (dt_ff == '0);
         deriv_ff   <= type_ff ? pidc_pkg::sat32(33'(trate_ff) - 33'(mrate_ff)) : '0;
      end
   end

   // ---------------- integral and accumulator ----------------
   assign sum_wide  = 64'(sum_ff);
   assign inc       = product >>> FRAC_BITS;
   assign sum_total = EXT_W'(sum_ff) + EXT_W'(inc);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (product_tag.valid && (product_tag.kind == pidc_pkg::MK_INC)) begin
         if (sum_total > SUM_MAX) begin
            sum_ff <= SUM_WIDTH'(SUM_MAX);
         end else if (sum_total < SUM_MIN) begin
            sum_ff <= SUM_WIDTH'(SUM_MIN);
         end else begin
            sum_ff <= SUM_WIDTH'(sum_total);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (product_tag.valid) begin
         case (product_tag.kind)
            pidc_pkg::MK_FIRST:  acc_ff <= ACC_W'(product);
            pidc_pkg::MK_ADD:    acc_ff <= acc_ff + ACC_W'(product);
            pidc_pkg::MK_ADD_HI: acc_ff <= acc_ff + (ACC_W'(product) <<< 32);
            default: ;
         endcase
      end
   end

   // ---------------- result ----------------
   assign acc_shifted = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (acc_shifted > DRIVE_MAX) begin
         drive_value = pidc_pkg::INT32_MAX;
      end else if (acc_shifted < DRIVE_MIN) begin
         drive_value = pidc_pkg::INT32_MIN;
      end else begin
         drive_value = acc_shifted[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_drive_ff <= drive_value;
         rsp_fault_ff <= fault_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_drive_ff;
   assign rsp_tuser[0] = rsp_fault_ff;

   // ---------------- shared units ----------------
   pidc_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .issue_tag   (issue_tag),
      .op_a        (op_a),
      .op_b        (op_b),
      .product     (product),
      .product_tag (product_tag)
   );

   pidc_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .diff      (div_diff),
      .step_time (dt_ff),
      .busy      (div_busy),
      .quotient  (div_quotient)
   );

   // ---------------- assertions ----------------
   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == pidc_pkg::ST_OUTPUT))
      else $error("result appeared outside the output step");

   a_div_in_window: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == pidc_pkg::ST_PROP || state_ff == pidc_pkg::ST_SUM_LO ||
                    state_ff == pidc_pkg::ST_SUM_HI || state_ff == pidc_pkg::ST_DERIV))
      else $error("divider running outside its window");

   a_mul_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pidc_pkg::ST_IDLE) |-> !product_tag.valid)
      else $error("multiplier product pending while idle");

endmodule

>>> dv/pid_controller_unit_test.sv
// Self-checking testbench for pid_controller_unit: random and directed PID steps.
module pid_controller_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF;
   localparam int SUM_WIDTH = pidc_pkg::SUM_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic MODE_DIFF = 1'b0;   // derivative from error difference over dt
   localparam logic MODE_RATE = 1'b1;   // derivative from supplied rates
   localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped, writes are dropped

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   typedef struct {
      logic               req_type;
      logic signed [31:0] target;
      logic signed [31:0] target_rate;
      logic signed [31:0] measured;
      logic signed [31:0] measured_rate;
      logic        [31:0] step_time;
   } pid_sample_type;

   typedef struct {
      logic [31:0] drive;
      logic        div_fault;
   } pid_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   pid_controller_unit #(
      .FRAC_BITS(FRAC_BITS),
      .SUM_WIDTH(SUM_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller state as the predictor sees it
   logic signed [127:0] kp_gain = '0;
   logic signed [127:0] ki_gain = '0;
   logic signed [127:0] kd_gain = '0;
   logic signed [127:0] err_prev = '0;
   logic signed [127:0] integral_sum = '0;

   pid_sample_type samples_to_send[$];
   pid_result_type due_results[$];
   pid_sample_type next_sample;
   pid_result_type want;
   int          queued_count = 0;
   int          sent_count = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   bit          idle_ok = 1'b1;
   bit          req_sent = 1'b0;

   function automatic logic signed [127:0] clamp_bits(input logic signed [127:0] v,
                                                     input int bits);
      logic signed [127:0] top;
      logic signed [127:0] bottom;
      top = (128'sd1 <<< (bits - 1)) - 128'sd1;
      bottom = -top - 128'sd1;
      if (v > top) return top;
      if (v < bottom) return bottom;
      return v;
   endfunction

   // one controller step; updates the integral, and in difference mode the last error
   function automatic pid_result_type pid_step(input pid_sample_type s);
      logic signed [127:0] lhs, rhs, err, dt, inc, diff, deriv, acc;
      logic [63:0]         numer, quot;
      pid_result_type      r;
      lhs = s.target;
      rhs = s.measured;
      err = clamp_bits(lhs - rhs, 32);
      dt = {96'd0, s.step_time};
      inc = (err * dt) >>> FRAC_BITS;
      integral_sum = clamp_bits(integral_sum + inc, SUM_WIDTH);
      r.div_fault = 1'b0;
      if (s.req_type == MODE_DIFF) begin
         if (s.step_time == '0) begin
            deriv = '0;
            r.div_fault = 1'b1;
         end else begin
            diff = err - err_prev;
            numer = (diff < 0) ? 64'(-diff) : 64'(diff);
            numer = numer << FRAC_BITS;
            quot = numer / {32'd0, s.step_time};
            deriv = {64'd0, quot};
            if (diff < 0) deriv = -deriv;
            deriv = clamp_bits(deriv, 32);
         end
         err_prev = err;
      end else begin
         lhs = s.target_rate;
         rhs = s.measured_rate;
         deriv = clamp_bits(lhs - rhs, 32);
      end
      acc = err * kp_gain + integral_sum * ki_gain + deriv * kd_gain;
      acc = clamp_bits(acc >>> FRAC_BITS, 32);
      r.drive = acc[31:0];
      return r;
   endfunction

   task automatic queue_sample(input logic mode, input logic [31:0] tgt, input logic [31:0] tgt_rate,
                               input logic [31:0] meas, input logic [31:0] meas_rate,
                               input logic [31:0] dt);
      pid_sample_type s;
      s.req_type = mode;
      s.target = tgt;
      s.target_rate = tgt_rate;
      s.measured = meas;
      s.measured_rate = meas_rate;
      s.step_time = dt;
      samples_to_send.push_back(s);
      queued_count++;
   endtask

   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return 32'h1;
      endcase
   endfunction

   function automatic logic [31:0] near_zero(input int unsigned span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic queue_random(input int count);
      logic [31:0] tgt, meas, dt;
      logic        mode;
      repeat (count) begin
         mode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            6, 7: queue_sample(mode, $urandom, $urandom, $urandom, $urandom, $urandom);
            8: begin
               tgt = near_zero(1 << 20);
               queue_sample(mode, tgt, near_zero(1 << 20), tgt + near_zero(1 << 17),
                            near_zero(1 << 20), 32'h0);
            end
            9: queue_sample(mode, edge_value(), edge_value(), edge_value(), edge_value(),
                            ($urandom_range(0, 1) == 1) ? edge_value() : $urandom);
            default: begin
               // plant tracking its setpoint: small errors, modest time steps
               tgt = near_zero(1 << 20);
               meas = tgt + near_zero(1 << 17);
               dt = $urandom_range(1, 32'h0002_0000);
               queue_sample(mode, tgt, near_zero(1 << 20), meas, near_zero(1 << 20), dt);
            end
         endcase
      end
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      logic signed [31:0] sv;
      sv = value;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         pidc_pkg::REG_GAIN_P: kp_gain = sv;
         pidc_pkg::REG_GAIN_I: ki_gain = sv;
         pidc_pkg::REG_GAIN_D: kd_gain = sv;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd);
      csr_write(pidc_pkg::REG_GAIN_P, kp);
      csr_write(pidc_pkg::REG_GAIN_I, ki);
      csr_write(pidc_pkg::REG_GAIN_D, kd);
   endtask

   task automatic drain();
      while (sent_count != queued_count || due_results.size() != 0) @(posedge clock);
   endtask

   // sender: next sample goes out once the previous one has transferred
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_sent) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (samples_to_send.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
            req_tvalid <= 1'b0;
         end else begin
            next_sample = samples_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {next_sample.step_time, next_sample.measured_rate,
                          next_sample.measured, next_sample.target_rate, next_sample.target};
            req_tuser <= next_sample.req_type;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_sent <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         next_sample.req_type = req_tuser[0];
         next_sample.target = req_tdata[31:0];
         next_sample.target_rate = req_tdata[63:32];
         next_sample.measured = req_tdata[95:64];
         next_sample.measured_rate = req_tdata[127:96];
         next_sample.step_time = req_tdata[159:128];
         due_results.push_back(pid_step(next_sample));
         sent_count++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            $error("unexpected transfer: drive %h div_fault %0b", rsp_tdata, rsp_tuser[0]);
            fail_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata !== want.drive) begin
               $error("drive: expected %h, got %h", want.drive, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.div_fault) begin
               $error("div_fault: expected %0b, got %0b", want.div_fault, rsp_tuser[0]);
               fail_count++;
            end
         end
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(REG_SPARE, 32'hDEAD_BEEF);
      set_gains(Q_ONE, 32'h0000_8000, 32'h0000_4000);

      // zero step: fault in difference mode, none in rate mode
      queue_sample(MODE_DIFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      queue_sample(MODE_DIFF, Q_ONE, 32'h0, 32'h0, 32'h0, Q_ONE);
      queue_sample(MODE_RATE, 32'h0002_0000, 32'h0000_8000, Q_ONE, 32'h0, 32'h0);
      // error saturates, integral runs into both bounds
      queue_sample(MODE_DIFF, Q_MAX, 32'h0, Q_MIN, 32'h0, 32'hFFFF_FFFF);
      queue_sample(MODE_DIFF, Q_MAX, 32'h0, Q_MIN, 32'h0, 32'hFFFF_FFFF);
      queue_sample(MODE_DIFF, Q_MIN, 32'h0, Q_MAX, 32'h0, 32'h1);
      queue_sample(MODE_DIFF, Q_MAX, 32'h0, Q_MIN, 32'h0, 32'h1);
      repeat (3) queue_sample(MODE_DIFF, Q_MIN, 32'h0, Q_MAX, 32'h0, 32'hFFFF_FFFF);
      // rate difference saturates both ways
      queue_sample(MODE_RATE, 32'h0, Q_MAX, 32'h0, Q_MIN, 32'h0000_8000);
      queue_sample(MODE_RATE, 32'h0, Q_MIN, 32'h0, Q_MAX, 32'h0000_8000);
      queue_sample(MODE_DIFF, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF);
      // zero step still moves the last error
      queue_sample(MODE_DIFF, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      queue_sample(MODE_DIFF, 32'h0001_0000, 32'h0, 32'h0, 32'h0, Q_ONE);
      queue_sample(MODE_RATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'h0);
      queue_sample(MODE_DIFF, Q_MIN, 32'h0, 32'h0, 32'h0, Q_MIN);
      queue_sample(MODE_RATE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, Q_MAX);
      queue_random(110);
      drain();

      set_gains(Q_MAX, Q_MAX, Q_MAX);
      queue_random(120);
      drain();

      set_gains(Q_MIN, Q_MIN, Q_MIN);
      queue_random(120);
      drain();

      set_gains($urandom, $urandom, $urandom);
      queue_random(130);
      drain();

      set_gains(32'hFFFF_0000, 32'h0, Q_MAX);
      queue_random(120);
      drain();

      // last stretch runs with no bubbles on either side
      idle_ok = 1'b0;
      set_gains(32'h0002_8000, 32'hFFFF_C000, 32'h0000_2000);
      queue_random(130);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
